[sv/upu_pkg.sv]
// shared constants for the unfolding pair update unit
// item kinds, register addresses, field widths and schedule constants
package upu_pkg;

    localparam int KIND_W     = 3;
    localparam int INDEX_W    = 10;
    localparam int DIM_W      = 3;
    localparam int COORD_W    = 32;
    localparam int STEP_W     = 16;
    localparam int SWEEP_W    = 11;
    localparam int UPS_W      = 12;
    localparam int DIMS_W     = 4;
    localparam int APB_AW     = 4;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 56;

    localparam logic [STEP_W-1:0] STEP_START  = 16'd32768;
    localparam logic [UPS_W-1:0]  SWEEP_LIMIT = 12'd2048;

    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_DIMS = 8;

    localparam logic [KIND_W-1:0] KIND_UPDATE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_ROW = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE_COL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ_ROW  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_COL  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESTART   = 3'd5;

    localparam logic [APB_AW-1:0] ADDR_DIMS  = 4'h0;
    localparam logic [APB_AW-1:0] ADDR_DECAY = 4'h4;
    localparam logic [APB_AW-1:0] ADDR_UPS   = 4'h8;

endpackage

[sv/unfolding_pair_update_unit.sv]
// unfolding pair update unit: top level with coordinate memories and sequencer
// depends on upu_pkg
//
// Row and column points live in two single-port synchronous memories (coordinate plus
// anchor flag per entry). One item is processed at a time. An update runs a distance pass,
// a bit-serial square root, a bit-serial divide and a move pass, in that order; the root
// and the divide each produce one bit per cycle.
// A new item is taken while a finished result still waits on the m_ side.
module unfolding_pair_update_unit #(
    parameter int MAX_ROWS = upu_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = upu_pkg::DEF_MAX_COLS,
    parameter int MAX_DIMS = upu_pkg::DEF_MAX_DIMS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row_index, col_index, dim_index, coord_value, fixed_flag, dissimilarity, pair_weighted
    input  logic [upu_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [upu_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value, skipped, current_step
    output logic [upu_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [upu_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import upu_pkg::*;

    localparam int ROW_DEPTH = MAX_ROWS * MAX_DIMS;
    localparam int COL_DEPTH = MAX_COLS * MAX_DIMS;
    localparam int ROW_AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int COL_AW = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
    localparam int KW = $clog2(MAX_DIMS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_WR, ST_RD_WAIT, ST_RD_DATA,
        ST_A_WAIT, ST_A_DIFF, ST_A_SQ, ST_A_ACC,
        ST_ROOT, ST_DIV,
        ST_B_WAIT, ST_B_DATA, ST_B_MUL_HI, ST_B_MUL_LO, ST_B_ERR, ST_B_STEP, ST_B_WB,
        ST_DONE
    } state_t;

    state_t state_reg;

    // input fields
    logic [INDEX_W-1:0] in_row, in_col;
    logic [DIM_W-1:0]   in_dim;
    logic [31:0]        in_coord, in_diss;
    logic               in_fixed, in_weighted;
    assign in_row      = s_tdata[9:0];
    assign in_col      = s_tdata[19:10];
    assign in_dim      = s_tdata[22:20];
    assign in_coord    = s_tdata[54:23];
    assign in_fixed    = s_tdata[55];
    assign in_diss     = s_tdata[87:56];
    assign in_weighted = s_tdata[88];

    logic s_fire;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // configuration
    logic [DIMS_W-1:0] dims_reg;
    logic [STEP_W-1:0] decay_reg;
    logic [UPS_W-1:0]  ups_reg;
    logic              cfg_write;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg  <= 4'd2;
            decay_reg <= 16'hFFFF;
            ups_reg   <= SWEEP_LIMIT;
        end else if (cfg_write) begin
            case (paddr)
                ADDR_DIMS:  dims_reg  <= pwdata[DIMS_W-1:0];
                ADDR_DECAY: decay_reg <= pwdata[STEP_W-1:0];
                ADDR_UPS:   ups_reg   <= pwdata[UPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_DIMS:  prdata = {28'd0, dims_reg};
            ADDR_DECAY: prdata = {16'd0, decay_reg};
            ADDR_UPS:   prdata = {20'd0, ups_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // sequencer registers
    logic [KIND_W-1:0]   kind_reg;
    logic [ROW_AW-1:0]   row_addr_reg;
    logic [COL_AW-1:0]   col_addr_reg;
    logic [INDEX_W-1:0]  row_sel_reg, col_sel_reg;
    logic [31:0]         wdata_reg;
    logic                wflag_reg;
    logic                ok_reg;
    logic [31:0]         delta_reg;
    logic [KW-1:0]       k_reg, p_reg;
    logic [STEP_W-1:0]   step_reg, mu_reg;
    logic [SWEEP_W-1:0]  sweep_reg;
    logic [31:0]         mag_reg;
    logic [63:0]         sq_reg;
    logic [71:0]         acc_reg;
    logic [35:0]         root_reg;
    logic [37:0]         rrem_reg;
    logic [47:0]         num_reg;
    logic [36:0]         drem_reg;
    logic [5:0]          iter_reg;
    logic [32:0]         diff_reg;
    logic [31:0]         x_reg, y_reg;
    logic                xa_reg, ya_reg;
    logic [55:0]         pp_hi_reg, pp_lo_reg;
    logic [34:0]         e_reg;
    logic [49:0]         sm_reg;
    logic [31:0]         res_read_reg;
    logic                res_skip_reg;
    logic [STEP_W-1:0]   res_step_reg;
    logic                m_valid_reg;
    logic [31:0]         m_read_reg;
    logic                m_skip_reg;
    logic [STEP_W-1:0]   m_step_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_step_reg, m_skip_reg, m_read_reg};

    // memories: {anchor, coordinate}
    logic [32:0] row_mem [ROW_DEPTH];
    logic [32:0] col_mem [COL_DEPTH];
    logic [32:0] row_rd_reg, col_rd_reg;
    logic        row_we, col_we;
    logic [32:0] row_wdata, col_wdata;

    // move pass arithmetic
    logic [79:0]  t_prod;
    logic [31:0]  tm;
    logic [33:0]  t_s;
    logic [33:0]  e_mag;
    logic [33:0]  sm;
    logic [35:0]  s_ext, xn, yn;
    logic [31:0]  x_sat, y_sat;

    function automatic logic [31:0] sat32(input logic [35:0] v);
        logic [31:0] r;
        if (!v[35] && (v[34:31] != 4'd0))     r = 32'h7FFF_FFFF;
        else if (v[35] && (v[34:31] != 4'hF)) r = 32'h8000_0000;
        else                                   r = v[31:0];
        return r;
    endfunction

    assign t_prod = {pp_hi_reg, 24'd0} + {24'd0, pp_lo_reg};
    assign tm     = t_prod[47:16];
    assign t_s    = diff_reg[32] ? -{2'b00, tm} : {2'b00, tm};
    assign e_mag  = e_reg[34] ? 34'(-e_reg) : e_reg[33:0];
    assign sm     = sm_reg[49:16];
    assign s_ext  = e_reg[34] ? -{2'b00, sm} : {2'b00, sm};
    assign xn     = {{4{x_reg[31]}}, x_reg} + s_ext;
    assign yn     = {{4{y_reg[31]}}, y_reg} - s_ext;
    assign x_sat  = sat32(xn);
    assign y_sat  = sat32(yn);

    always_comb begin
        row_we    = 1'b0;
        col_we    = 1'b0;
        row_wdata = {xa_reg, x_sat};
        col_wdata = {ya_reg, y_sat};
        if (state_reg == ST_WR && ok_reg) begin
            row_we    = (kind_reg == KIND_WRITE_ROW);
            col_we    = (kind_reg == KIND_WRITE_COL);
            row_wdata = {wflag_reg, wdata_reg};
            col_wdata = {wflag_reg, wdata_reg};
        end else if (state_reg == ST_B_WB) begin
            row_we = !xa_reg;
            col_we = !ya_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_we) row_mem[row_addr_reg] <= row_wdata;
        row_rd_reg <= row_mem[row_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (col_we) col_mem[col_addr_reg] <= col_wdata;
        col_rd_reg <= col_mem[col_addr_reg];
    end

    // address generation
    function automatic logic [ROW_AW-1:0] row_addr(input logic [INDEX_W-1:0] r,
                                                   input logic [4:0] d);
        logic [31:0] lin;
        lin = 32'(r) * 32'(MAX_DIMS) + 32'(d);
        return lin[ROW_AW-1:0];
    endfunction

    function automatic logic [COL_AW-1:0] col_addr(input logic [INDEX_W-1:0] c,
                                                   input logic [4:0] d);
        logic [31:0] lin;
        lin = 32'(c) * 32'(MAX_DIMS) + 32'(d);
        return lin[COL_AW-1:0];
    endfunction

    // accept-time decode
    logic        rows_ok, cols_ok, dim_ok;
    logic [KW-1:0] p_next;
    logic [UPS_W-1:0] limit;
    logic [UPS_W-1:0] sweep_inc;
    logic [31:0] decay_prod;
    assign rows_ok   = 32'(in_row) < 32'(MAX_ROWS);
    assign cols_ok   = 32'(in_col) < 32'(MAX_COLS);
    assign dim_ok    = 32'(in_dim) < 32'(MAX_DIMS);
    assign p_next    = (32'(dims_reg) > 32'(MAX_DIMS)) ? KW'(MAX_DIMS) : KW'(dims_reg);
    assign limit     = (ups_reg == '0) ? 12'd1 :
                       (ups_reg > SWEEP_LIMIT) ? SWEEP_LIMIT : ups_reg;
    assign sweep_inc = {1'b0, sweep_reg} + 12'd1;
    assign decay_prod = step_reg * decay_reg;

    // root and divide steps
    logic [37:0] r_sh, r_trial;
    logic [36:0] d_sh;
    logic [36:0] d_div;
    assign r_sh    = {rrem_reg[35:0], acc_reg[71:70]};
    assign r_trial = {root_reg, 2'b01};
    assign d_sh    = {drem_reg[35:0], num_reg[47]};
    assign d_div   = {1'b0, root_reg};

    logic [32:0] xy_diff;
    logic [KW-1:0] k_inc;
    assign xy_diff = {row_rd_reg[31], row_rd_reg[31:0]} - {col_rd_reg[31], col_rd_reg[31:0]};
    assign k_inc   = k_reg + KW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_START;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != ST_DONE) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        kind_reg     <= s_tuser;
                        row_sel_reg  <= in_row;
                        col_sel_reg  <= in_col;
                        wdata_reg    <= in_coord;
                        wflag_reg    <= in_fixed;
                        delta_reg    <= in_diss;
                        p_reg        <= p_next;
                        k_reg        <= '0;
                        mu_reg       <= step_reg;
                        acc_reg      <= '0;
                        res_read_reg <= '0;
                        res_skip_reg <= 1'b0;
                        res_step_reg <= step_reg;
                        row_addr_reg <= row_addr(in_row, (s_tuser == KIND_UPDATE) ? 5'd0 : 5'(in_dim));
                        col_addr_reg <= col_addr(in_col, (s_tuser == KIND_UPDATE) ? 5'd0 : 5'(in_dim));
                        case (s_tuser)
                            KIND_UPDATE: begin
                                if (sweep_inc >= limit) begin
                                    sweep_reg <= '0;
                                    step_reg  <= decay_prod[31:16];
                                end else begin
                                    sweep_reg <= sweep_inc[SWEEP_W-1:0];
                                end
                                if (!in_weighted || !rows_ok || !cols_ok || p_next == '0) begin
                                    res_skip_reg <= 1'b1;
                                    state_reg    <= ST_DONE;
                                end else begin
                                    state_reg <= ST_A_WAIT;
                                end
                            end
                            KIND_WRITE_ROW, KIND_READ_ROW: begin
                                ok_reg    <= rows_ok && dim_ok;
                                state_reg <= (s_tuser == KIND_WRITE_ROW) ? ST_WR : ST_RD_WAIT;
                            end
                            KIND_WRITE_COL, KIND_READ_COL: begin
                                ok_reg    <= cols_ok && dim_ok;
                                state_reg <= (s_tuser == KIND_WRITE_COL) ? ST_WR : ST_RD_WAIT;
                            end
                            KIND_RESTART: begin
                                step_reg     <= STEP_START;
                                sweep_reg    <= '0;
                                res_step_reg <= STEP_START;
                                state_reg    <= ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_WR: state_reg <= ST_DONE;
                ST_RD_WAIT: state_reg <= ST_RD_DATA;
                ST_RD_DATA: begin
                    if (ok_reg) begin
                        res_read_reg <= (kind_reg == KIND_READ_ROW) ? row_rd_reg[31:0]
                                                                   : col_rd_reg[31:0];
                    end
                    state_reg <= ST_DONE;
                end
                ST_A_WAIT: state_reg <= ST_A_DIFF;
                ST_A_DIFF: begin
                    mag_reg      <= xy_diff[32] ? 32'(-xy_diff) : xy_diff[31:0];
                    row_addr_reg <= row_addr(row_sel_reg, 5'(k_inc));
                    col_addr_reg <= col_addr(col_sel_reg, 5'(k_inc));
                    k_reg        <= k_inc;
                    state_reg    <= ST_A_SQ;
                end
                ST_A_SQ: begin
                    sq_reg    <= mag_reg * mag_reg;
                    state_reg <= ST_A_ACC;
                end
                ST_A_ACC: begin
                    acc_reg <= acc_reg + {8'd0, sq_reg};
                    if (k_reg == p_reg) begin
                        root_reg  <= '0;
                        rrem_reg  <= '0;
                        iter_reg  <= '0;
                        state_reg <= ST_ROOT;
                    end else begin
                        state_reg <= ST_A_DIFF;
                    end
                end
                ST_ROOT: begin
                    acc_reg  <= {acc_reg[69:0], 2'b00};
                    iter_reg <= iter_reg + 6'd1;
                    if (r_sh >= r_trial) begin
                        rrem_reg <= r_sh - r_trial;
                        root_reg <= {root_reg[34:0], 1'b1};
                    end else begin
                        rrem_reg <= r_sh;
                        root_reg <= {root_reg[34:0], 1'b0};
                    end
                    if (iter_reg == 6'd35) begin
                        iter_reg  <= '0;
                        num_reg   <= {delta_reg, 16'd0};
                        drem_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (root_reg == '0) begin
                        res_skip_reg <= 1'b1;
                        state_reg    <= ST_DONE;
                    end else begin
                        iter_reg <= iter_reg + 6'd1;
                        if (d_sh >= d_div) begin
                            drem_reg <= d_sh - d_div;
                            num_reg  <= {num_reg[46:0], 1'b1};
                        end else begin
                            drem_reg <= d_sh;
                            num_reg  <= {num_reg[46:0], 1'b0};
                        end
                        if (iter_reg == 6'd47) begin
                            k_reg        <= '0;
                            row_addr_reg <= row_addr(row_sel_reg, 5'd0);
                            col_addr_reg <= col_addr(col_sel_reg, 5'd0);
                            state_reg    <= ST_B_WAIT;
                        end
                    end
                end
                ST_B_WAIT: state_reg <= ST_B_DATA;
                ST_B_DATA: begin
                    x_reg     <= row_rd_reg[31:0];
                    xa_reg    <= row_rd_reg[32];
                    y_reg     <= col_rd_reg[31:0];
                    ya_reg    <= col_rd_reg[32];
                    diff_reg  <= xy_diff;
                    mag_reg   <= xy_diff[32] ? 32'(-xy_diff) : xy_diff[31:0];
                    state_reg <= ST_B_MUL_HI;
                end
                ST_B_MUL_HI: begin
                    pp_hi_reg <= num_reg[47:24] * mag_reg;
                    state_reg <= ST_B_MUL_LO;
                end
                ST_B_MUL_LO: begin
                    pp_lo_reg <= num_reg[23:0] * mag_reg;
                    state_reg <= ST_B_ERR;
                end
                ST_B_ERR: begin
                    e_reg     <= {t_s[33], t_s} - {{2{diff_reg[32]}}, diff_reg};
                    state_reg <= ST_B_STEP;
                end
                ST_B_STEP: begin
                    sm_reg    <= mu_reg * e_mag;
                    state_reg <= ST_B_WB;
                end
                ST_B_WB: begin
                    k_reg <= k_inc;
                    if (k_inc == p_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        row_addr_reg <= row_addr(row_sel_reg, 5'(k_inc));
                        col_addr_reg <= col_addr(col_sel_reg, 5'(k_inc));
                        state_reg    <= ST_B_WAIT;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_read_reg  <= res_read_reg;
                        m_skip_reg  <= res_skip_reg;
                        m_step_reg  <= res_step_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_START)
        else $error("step size above one half");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, sweep_reg} < SWEEP_LIMIT)
        else $error("sweep counter out of range");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == KIND_RESTART) |=> (step_reg == STEP_START && sweep_reg == '0))
        else $error("restart did not reset the schedule");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second request taken while busy");
`endif

endmodule

[tb/tb_top.sv]
// self-checking testbench for unfolding_pair_update_unit: stream requests in, results checked
// against an in-bench fixed-point model of the coordinate stores and step schedule
// depends on upu_pkg and unfolding_pair_update_unit
module tb_top;
    import upu_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int SETTLE = 300;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
        logic [DIM_W-1:0]   dim;
        logic [COORD_W-1:0] coord;
        logic               anchor;
        logic [31:0]        diss;
        logic               weighted;
    } pair_req_t;

    typedef struct {
        logic [COORD_W-1:0] read_value;
        logic               skipped;
        logic [STEP_W-1:0]  step;
    } pair_res_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    unfolding_pair_update_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // model state
    logic [31:0] row_mem [8192];
    logic [31:0] col_mem [8192];
    logic        row_fix [8192];
    logic        col_fix [8192];
    logic [15:0] mu;
    int unsigned sweep_cnt;
    logic [3:0]  cfg_dims;
    logic [15:0] cfg_decay;
    logic [11:0] cfg_ups;

    pair_res_t   pending_results [$];
    int          errors;
    int          cycles;
    bit          no_idle;
    int          last_row_addr;
    int          last_col_addr;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL unfolding_pair_update_unit");
            $finish;
        end
    end

    function automatic longint to_s(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic logic [31:0] clamp_word(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // one pair move; returns 1 when the update is skipped (unweighted or zero distance)
    function automatic bit move_pair(logic [9:0] r, logic [9:0] c, logic [31:0] delta, logic wt);
        longint      dif [8];
        logic [71:0] acc;
        logic [79:0] rem;
        logic [79:0] trial;
        logic [63:0] root;
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] tm;
        logic [63:0] sm;
        longint      t;
        longint      e;
        longint      s;
        int          p;
        int          rb;
        int          cb;
        if (!wt) return 1'b1;
        p = (cfg_dims > 8) ? 8 : cfg_dims;
        rb = r * 8;
        cb = c * 8;
        acc = '0;
        for (int k = 0; k < p; k++) begin
            dif[k] = to_s(row_mem[rb+k]) - to_s(col_mem[cb+k]);
            m = (dif[k] < 0) ? 64'(-dif[k]) : 64'(dif[k]);
            acc = acc + 72'(m * m);
        end
        rem = '0;
        root = '0;
        for (int i = 35; i >= 0; i--) begin
            rem = (rem << 2) | 80'(acc[2*i +: 2]);
            trial = 80'((root << 2) | 64'd1);
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        if (root == 0) return 1'b1;
        b = ({32'd0, delta} << 16) / root;
        for (int k = 0; k < p; k++) begin
            m = (dif[k] < 0) ? 64'(-dif[k]) : 64'(dif[k]);
            tm = (b * m) >> 16;
            t = (dif[k] < 0) ? -longint'(tm) : longint'(tm);
            e = t - dif[k];
            m = (e < 0) ? 64'(-e) : 64'(e);
            sm = (64'(mu) * m) >> 16;
            s = (e < 0) ? -longint'(sm) : longint'(sm);
            if (!row_fix[rb+k]) row_mem[rb+k] = clamp_word(to_s(row_mem[rb+k]) + s);
            if (!col_fix[cb+k]) col_mem[cb+k] = clamp_word(to_s(col_mem[cb+k]) - s);
        end
        return 1'b0;
    endfunction

    function automatic pair_res_t apply_request(pair_req_t q);
        pair_res_t o;
        int        a;
        int unsigned lim;
        o.read_value = '0;
        o.skipped = 1'b0;
        o.step = mu;
        case (q.kind)
            KIND_UPDATE: begin
                lim = (cfg_ups > SWEEP_LIMIT) ? SWEEP_LIMIT : cfg_ups;
                o.skipped = move_pair(q.row, q.col, q.diss, q.weighted);
                if (sweep_cnt + 1 >= lim) begin
                    sweep_cnt = 0;
                    mu = 16'((32'(mu) * 32'(cfg_decay)) >> 16);
                end else begin
                    sweep_cnt = sweep_cnt + 1;
                end
            end
            KIND_WRITE_ROW: begin
                a = q.row * 8 + q.dim;
                row_mem[a] = q.coord;
                row_fix[a] = q.anchor;
            end
            KIND_WRITE_COL: begin
                a = q.col * 8 + q.dim;
                col_mem[a] = q.coord;
                col_fix[a] = q.anchor;
            end
            KIND_READ_ROW: o.read_value = row_mem[q.row * 8 + q.dim];
            KIND_READ_COL: o.read_value = col_mem[q.col * 8 + q.dim];
            KIND_RESTART: begin
                mu = STEP_START;
                sweep_cnt = 0;
                o.step = mu;
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_request(pair_req_t q);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= q.kind;
        s_tdata <= {7'd0, q.weighted, q.diss, q.anchor, q.coord, q.dim, q.col, q.row};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_request(q));
    endtask

    task automatic stop_requests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        pair_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.read_value) begin
                    $display("%0t read_value exp %h got %h", $time, want.read_value,
                             m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[32] !== want.skipped) begin
                    $display("%0t skipped exp %b got %b", $time, want.skipped, m_tdata[32]);
                    errors++;
                end
                if (m_tdata[48:33] !== want.step) begin
                    $display("%0t current_step exp %h got %h", $time, want.step,
                             m_tdata[48:33]);
                    errors++;
                end
            end
        end
    end

    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 16);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic wait_idle();
        stop_requests();
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_DIMS: cfg_dims = data[3:0];
            ADDR_DECAY: cfg_decay = data[15:0];
            ADDR_UPS: cfg_ups = data[11:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [3:0] d, logic [15:0] dk, logic [11:0] u);
        wait_idle();
        apb_write(ADDR_DIMS, 32'(d));
        apb_write(ADDR_DECAY, 32'(dk));
        apb_write(ADDR_UPS, 32'(u));
    endtask

    function automatic logic [9:0] pool_point(int i);
        return (i == 7) ? 10'd1023 : 10'(i);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
        endcase
    endfunction

    function automatic pair_req_t blank_req(logic [KIND_W-1:0] k);
        pair_req_t q;
        q = '{kind: k, row: '0, col: '0, dim: '0, coord: '0, anchor: 1'b0,
              diss: '0, weighted: 1'b0};
        return q;
    endfunction

    task automatic put_coord(bit is_col, logic [9:0] idx, logic [2:0] d, logic [31:0] v,
                             logic fx);
        pair_req_t q;
        q = blank_req(is_col ? KIND_WRITE_COL : KIND_WRITE_ROW);
        q.row = idx;
        q.col = idx;
        q.dim = d;
        q.coord = v;
        q.anchor = fx;
        send_request(q);
    endtask

    task automatic get_coord(bit is_col, logic [9:0] idx, logic [2:0] d);
        pair_req_t q;
        q = blank_req(is_col ? KIND_READ_COL : KIND_READ_ROW);
        q.row = idx;
        q.col = idx;
        q.dim = d;
        send_request(q);
    endtask

    task automatic do_update(logic [9:0] r, logic [9:0] c, logic [31:0] dl, logic wt);
        pair_req_t q;
        q = blank_req(KIND_UPDATE);
        q.row = r;
        q.col = c;
        q.diss = dl;
        q.weighted = wt;
        send_request(q);
    endtask

    // every pool point gets all eight coordinates so updates never see unwritten entries
    task automatic test_fill_pool();
        for (int i = 0; i < 8; i++)
            for (int d = 0; d < 8; d++) begin
                put_coord(1'b0, pool_point(i), 3'(d),
                          32'($signed($urandom_range(0, 1310720)) - 655360),
                          $urandom_range(0, 3) == 0);
                put_coord(1'b1, pool_point(i), 3'(d),
                          32'($signed($urandom_range(0, 1310720)) - 655360),
                          $urandom_range(0, 3) == 0);
            end
    endtask

    task automatic test_directed();
        pair_req_t q;
        // extreme coordinates on the highest point, read back
        put_coord(1'b0, 10'd1023, 3'd7, 32'h80000000, 1'b1);
        get_coord(1'b0, 10'd1023, 3'd7);
        put_coord(1'b1, 10'd1023, 3'd7, 32'hFFFFFFFF, 1'b1);
        get_coord(1'b1, 10'd1023, 3'd7);
        // saturation: small distance, huge dissimilarity
        for (int d = 0; d < 7; d++) begin
            put_coord(1'b0, 10'd1023, 3'(d), (d == 0) ? 32'h7FFFFFFF : 32'h0, 1'b0);
            put_coord(1'b1, 10'd1023, 3'(d), (d == 0) ? 32'h7FFF0000 : 32'h0, 1'b0);
        end
        do_update(10'd1023, 10'd1023, 32'hFFFFFFFF, 1'b1);
        get_coord(1'b0, 10'd1023, 3'd0);
        get_coord(1'b1, 10'd1023, 3'd0);
        // zero weight
        do_update(10'd3, 10'd5, 32'h00010000, 1'b0);
        // zero distance, then zero dissimilarity
        put_coord(1'b0, 10'd6, 3'd0, 32'h00012345, 1'b0);
        put_coord(1'b0, 10'd6, 3'd1, 32'hFFFF0000, 1'b0);
        put_coord(1'b1, 10'd6, 3'd0, 32'h00012345, 1'b0);
        put_coord(1'b1, 10'd6, 3'd1, 32'hFFFF0000, 1'b0);
        do_update(10'd6, 10'd6, 32'h00020000, 1'b1);
        do_update(10'd1, 10'd2, 32'h0, 1'b1);
        // schedule restart and unused kinds
        send_request(blank_req(KIND_RESTART));
        for (int k = 6; k < 8; k++) begin
            q = blank_req(3'(k));
            q.row = 10'h3FF;
            q.diss = 32'hFFFFFFFF;
            send_request(q);
        end
    endtask

    task automatic random_item();
        pair_req_t q;
        int sel;
        sel = $urandom_range(0, 99);
        q = blank_req(KIND_UPDATE);
        q.row = pool_point($urandom_range(0, 7));
        q.col = pool_point($urandom_range(0, 7));
        q.dim = 3'($urandom_range(0, 7));
        if (sel < 45) begin
            q.weighted = 1'b1;
            q.diss = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 21);
        end else if (sel < 50) begin
            q.row = 10'($urandom());
            q.col = 10'($urandom());
            q.diss = $urandom();
        end else if (sel < 68) begin
            q.kind = $urandom_range(0, 1) ? KIND_WRITE_COL : KIND_WRITE_ROW;
            q.coord = rand_coord();
            q.anchor = $urandom_range(0, 3) == 0;
        end else if (sel < 73) begin
            q.kind = $urandom_range(0, 1) ? KIND_WRITE_COL : KIND_WRITE_ROW;
            q.row = 10'($urandom());
            q.col = 10'($urandom());
            q.coord = $urandom();
            q.anchor = 1'($urandom_range(0, 1));
            if (q.kind == KIND_WRITE_ROW) last_row_addr = q.row * 8 + q.dim;
            else last_col_addr = q.col * 8 + q.dim;
        end else if (sel < 88) begin
            q.kind = $urandom_range(0, 1) ? KIND_READ_COL : KIND_READ_ROW;
            if ($urandom_range(0, 2) == 0) begin
                q.row = 10'(last_row_addr / 8);
                q.col = 10'(last_col_addr / 8);
                q.dim = (q.kind == KIND_READ_ROW) ? 3'(last_row_addr % 8)
                                                  : 3'(last_col_addr % 8);
            end
        end else if (sel < 93) begin
            q.kind = KIND_RESTART;
        end else begin
            q.kind = 3'($urandom_range(6, 7));
            q.row = 10'($urandom());
            q.col = 10'($urandom());
            q.dim = 3'($urandom());
            q.coord = $urandom();
            q.anchor = 1'($urandom_range(0, 1));
            q.diss = $urandom();
            q.weighted = 1'($urandom_range(0, 1));
        end
        send_request(q);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            random_item();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_config_sweep();
        set_config(4'd1, 16'd0, 12'd1);
        test_random(200);
        set_config(4'd8, 16'd65535, 12'd0);
        test_random(250);
        set_config(4'd15, 16'd40000, 12'd4095);
        test_random(250);
        set_config(4'd0, 16'd50000, 12'd3);
        test_random(200);
        set_config(4'd3, 16'd60000, 12'd2048);
        test_random(250);
        set_config(4'd8, 16'd62000, 12'd7);
        test_random(250);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        mu = STEP_START;
        sweep_cnt = 0;
        cfg_dims = 4'd2;
        cfg_decay = 16'd65535;
        cfg_ups = 12'd2048;
        last_row_addr = 1023 * 8 + 7;
        last_col_addr = 1023 * 8 + 7;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fill_pool();
        test_directed();
        test_random(400);
        test_config_sweep();
        wait_idle();
        if (errors == 0) begin
            $display("PASS unfolding_pair_update_unit");
        end else begin
            $display("FAIL unfolding_pair_update_unit");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/upu_pkg.sv
sv/unfolding_pair_update_unit.sv
tb/tb_top.sv
